// ===== rtl/stl_pkg.sv =====
// Shared types and character/operator codes for the script token lexer.
package stl_pkg;

    // Output field widths
    localparam int POS_OUT_W = 24;
    localparam int LEN_OUT_W = 16;

    // Token kinds
    localparam logic [2:0] KIND_OP    = 3'd0;
    localparam logic [2:0] KIND_IDENT = 3'd1;
    localparam logic [2:0] KIND_NUM   = 3'd2;
    localparam logic [2:0] KIND_STR   = 3'd3;
    localparam logic [2:0] KIND_SYM   = 3'd4;
    localparam logic [2:0] KIND_END   = 3'd5;

    // Operator codes
    localparam logic [7:0] OP_BIND     = 8'd0;   // :=
    localparam logic [7:0] OP_SET      = 8'd1;   // =
    localparam logic [7:0] OP_EQ       = 8'd2;   // ==
    localparam logic [7:0] OP_NE       = 8'd3;   // !=
    localparam logic [7:0] OP_NOT      = 8'd4;   // !
    localparam logic [7:0] OP_ADD      = 8'd5;   // +
    localparam logic [7:0] OP_SUB      = 8'd6;   // -
    localparam logic [7:0] OP_MUL      = 8'd7;   // *
    localparam logic [7:0] OP_DIV      = 8'd8;   // /
    localparam logic [7:0] OP_GT       = 8'd9;   // >
    localparam logic [7:0] OP_GE       = 8'd10;  // >=
    localparam logic [7:0] OP_LT       = 8'd11;  // <
    localparam logic [7:0] OP_LE       = 8'd12;  // <=
    localparam logic [7:0] OP_LARROW   = 8'd13;  // <-
    localparam logic [7:0] OP_RARROW   = 8'd14;  // ->
    localparam logic [7:0] OP_OR       = 8'd15;  // ||
    localparam logic [7:0] OP_AND      = 8'd16;  // &&

    // Characters
    localparam logic [7:0] CH_EOF    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // One result word
    typedef struct packed {
        logic [2:0]           kind;
        logic [7:0]           code;
        logic [POS_OUT_W-1:0] start_pos;
        logic [LEN_OUT_W-1:0] len;
        logic                 space_before;
        logic                 newline_before;
        logic [POS_OUT_W-1:0] line_no;
        logic                 unterminated;
        logic                 last;
    } tok_t;

    // Results produced by one input byte, oldest in t0
    typedef struct packed {
        logic [1:0] cnt;
        tok_t       t0;
        tok_t       t1;
    } push_t;

endpackage

// ===== rtl/stl_lexer_core.sv =====
// Lexer state and single-pass next-state logic: one byte in, up to two tokens out.
module stl_lexer_core #(
    parameter int POSITION_BITS = 24,
    parameter int LENGTH_BITS   = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    ch,
    output stl_pkg::push_t push
);
    import stl_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_PEND, PH_IDENT, PH_NUM_INT, PH_NUM_FRAC,
        PH_STRING, PH_LINE_COMMENT, PH_BLOCK, PH_BLOCK_DASH
    } phase_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
    localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0]   LEN_TWO = LENGTH_BITS'(2);

    phase_t                   phase_reg, phase_next;
    logic [7:0]               held_reg, held_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic                     sp_reg, sp_next;
    logic                     nl_reg, nl_next;
    logic                     ended_reg, ended_next;

    // Working variables of the combinational pass
    logic                     sp, nl;
    logic                     do_flush, do_idle;
    logic                     a_req, b_req;
    logic [2:0]               a_kind, b_kind;
    logic [7:0]               a_code, b_code;
    logic [LENGTH_BITS-1:0]   a_len, b_len;
    logic                     a_unterm;
    logic [POSITION_BITS-1:0] b_start;
    logic [8:0]               pair;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [LENGTH_BITS-1:0]   len_inc;
    logic                     is_word, is_digit, is_alpha;
    tok_t                     tok_a, tok_b;

    function automatic tok_t make_tok(
        input logic [2:0]               kind,
        input logic [7:0]               code,
        input logic [POSITION_BITS-1:0] start,
        input logic [LENGTH_BITS-1:0]   len,
        input logic                     unterm,
        input logic                     f_sp,
        input logic                     f_nl,
        input logic [POSITION_BITS-1:0] line
    );
        tok_t t;
        t.kind           = kind;
        t.code           = code;
        t.start_pos      = POS_OUT_W'(start);
        t.len            = LEN_OUT_W'(len);
        t.space_before   = f_sp;
        t.newline_before = f_nl;
        t.line_no        = POS_OUT_W'(line);
        t.unterminated   = unterm;
        t.last           = 1'b0;
        return t;
    endfunction

    // Two-byte operator from held byte h and next byte c: {valid, code}
    function automatic logic [8:0] pair_op(input logic [7:0] h, input logic [7:0] c);
        logic [8:0] r;
        r = '0;
        case (h)
            CH_COLON: if (c == CH_EQ) r = {1'b1, OP_BIND};
            CH_EQ:    if (c == CH_EQ) r = {1'b1, OP_EQ};
            CH_BANG:  if (c == CH_EQ) r = {1'b1, OP_NE};
            CH_GT:    if (c == CH_EQ) r = {1'b1, OP_GE};
            CH_LT: begin
                if (c == CH_EQ)        r = {1'b1, OP_LE};
                else if (c == CH_DASH) r = {1'b1, OP_LARROW};
            end
            CH_DASH:  if (c == CH_GT)  r = {1'b1, OP_RARROW};
            CH_BAR:   if (c == CH_BAR) r = {1'b1, OP_OR};
            CH_AMP:   if (c == CH_AMP) r = {1'b1, OP_AND};
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign len_inc  = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;
    assign is_digit = ch inside {[8'h30:8'h39]};
    assign is_alpha = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    assign is_word  = is_alpha || is_digit || (ch == CH_UNDER);
    assign pair     = pair_op(held_reg, ch);

    // Next state and emitted tokens for the byte on ch
    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        start_next = start_reg;
        len_next   = len_reg;
        ended_next = ended_reg;
        sp         = sp_reg;
        nl         = nl_reg;
        do_flush   = 1'b0;
        do_idle    = 1'b0;
        a_req      = 1'b0;
        a_kind     = KIND_OP;
        a_code     = '0;
        a_len      = len_reg;
        a_unterm   = 1'b0;
        b_req      = 1'b0;
        b_kind     = KIND_OP;
        b_code     = '0;
        b_len      = LEN_ONE;
        b_start    = pos_reg;
        tok_a      = '0;
        tok_b      = '0;

        if (accept && !ended_reg) begin
            // Per-phase handling of the byte; a zero byte flushes the pending token
            if (ch == CH_EOF) begin
                do_flush = 1'b1;
            end else begin
                case (phase_reg)
                    PH_PEND: begin
                        if (held_reg == CH_DASH && ch == CH_DASH) begin
                            phase_next = PH_LINE_COMMENT;
                            sp = 1'b1;
                        end else if (held_reg == CH_LBRACE && ch == CH_DASH) begin
                            phase_next = PH_BLOCK;
                            sp = 1'b1;
                        end else if (pair[8]) begin
                            b_req      = 1'b1;
                            b_kind     = KIND_OP;
                            b_code     = pair[7:0];
                            b_start    = start_reg;
                            b_len      = LEN_TWO;
                            phase_next = PH_IDLE;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    PH_IDENT: begin
                        if (is_word) begin
                            len_next = len_inc;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    PH_NUM_INT, PH_NUM_FRAC: begin
                        if (is_digit) begin
                            len_next = len_inc;
                        end else if (ch == CH_DOT && phase_reg == PH_NUM_INT) begin
                            len_next   = len_inc;
                            phase_next = PH_NUM_FRAC;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    PH_STRING: begin
                        if (ch == CH_QUOTE) begin
                            b_req      = 1'b1;
                            b_kind     = KIND_STR;
                            b_start    = start_reg;
                            b_len      = len_reg;
                            phase_next = PH_IDLE;
                        end else begin
                            len_next = len_inc;
                        end
                    end
                    PH_LINE_COMMENT: begin
                        if (ch == CH_NL) begin
                            nl = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_BLOCK, PH_BLOCK_DASH: begin
                        if (phase_reg == PH_BLOCK_DASH && ch == CH_RBRACE) begin
                            sp = 1'b1;
                            phase_next = PH_IDLE;
                        end else if (ch == CH_DASH) begin
                            phase_next = PH_BLOCK_DASH;
                        end else begin
                            if (ch == CH_NL) nl = 1'b1;
                            phase_next = PH_BLOCK;
                        end
                    end
                    default: do_idle = 1'b1;
                endcase
            end

            // Report the pending token as complete
            if (do_flush) begin
                a_req = 1'b1;
                case (phase_reg)
                    PH_PEND: begin
                        a_len = LEN_ONE;
                        case (held_reg)
                            CH_EQ:   a_code = OP_SET;
                            CH_BANG: a_code = OP_NOT;
                            CH_DASH: a_code = OP_SUB;
                            CH_GT:   a_code = OP_GT;
                            CH_LT:   a_code = OP_LT;
                            default: begin
                                a_kind = KIND_SYM;
                                a_code = held_reg;
                            end
                        endcase
                    end
                    PH_IDENT:                a_kind = KIND_IDENT;
                    PH_NUM_INT, PH_NUM_FRAC: a_kind = KIND_NUM;
                    PH_STRING: begin
                        a_kind   = KIND_STR;
                        a_unterm = 1'b1;
                    end
                    default: a_req = 1'b0;
                endcase
                if (a_req) begin
                    tok_a = make_tok(a_kind, a_code, start_reg, a_len, a_unterm,
                                     sp, nl, line_reg);
                    sp = 1'b0;
                    nl = 1'b0;
                end
                phase_next = PH_IDLE;
            end

            // End of input, or a byte seen with nothing pending
            if (ch == CH_EOF) begin
                sp         = 1'b0;
                nl         = 1'b0;
                b_req      = 1'b1;
                b_kind     = KIND_END;
                b_len      = '0;
                ended_next = 1'b1;
            end else if (do_idle) begin
                phase_next = PH_IDLE;
                if (ch == CH_SPACE || (ch inside {[8'h09:8'h0D]})) begin
                    sp = 1'b1;
                    if (ch == CH_NL) nl = 1'b1;
                end else begin
                    start_next = pos_reg;
                    len_next   = LEN_ONE;
                    case (ch)
                        CH_COLON, CH_EQ, CH_DASH, CH_BANG, CH_GT, CH_LT,
                        CH_BAR, CH_AMP, CH_LBRACE: begin
                            phase_next = PH_PEND;
                            held_next  = ch;
                        end
                        CH_PLUS: begin
                            b_req  = 1'b1;
                            b_code = OP_ADD;
                        end
                        CH_STAR: begin
                            b_req  = 1'b1;
                            b_code = OP_MUL;
                        end
                        CH_SLASH: begin
                            b_req  = 1'b1;
                            b_code = OP_DIV;
                        end
                        CH_QUOTE: begin
                            phase_next = PH_STRING;
                            start_next = pos_inc;
                            len_next   = '0;
                        end
                        default: begin
                            if (is_alpha || ch == CH_UNDER) begin
                                phase_next = PH_IDENT;
                            end else if (is_digit) begin
                                phase_next = PH_NUM_INT;
                            end else begin
                                b_req  = 1'b1;
                                b_kind = KIND_SYM;
                                b_code = ch;
                            end
                        end
                    endcase
                end
            end

            if (b_req) begin
                tok_b = make_tok(b_kind, b_code, b_start, b_len, 1'b0, sp, nl, line_reg);
                sp = 1'b0;
                nl = 1'b0;
            end

            // Position and line counters advance after the byte
            if (ch != CH_EOF) begin
                if (ch == CH_NL) begin
                    line_next = (line_reg == POS_MAX) ? line_reg : line_reg + 1'b1;
                end
                pos_next = pos_inc;
            end
        end

        sp_next = sp;
        nl_next = nl;
    end

    // Order the tokens of this byte and mark the final one
    always_comb begin
        push.cnt     = {1'b0, a_req} + {1'b0, b_req};
        push.t0      = a_req ? tok_a : tok_b;
        push.t0.last = !(a_req && b_req);
        push.t1      = tok_b;
        push.t1.last = 1'b1;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
            pos_reg   <= '0;
            line_reg  <= POSITION_BITS'(1);
            start_reg <= '0;
            len_reg   <= '0;
            sp_reg    <= 1'b0;
            nl_reg    <= 1'b0;
            ended_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            sp_reg    <= sp_next;
            nl_reg    <= nl_next;
            ended_reg <= ended_next;
        end
    end

endmodule

// ===== rtl/stl_out_queue.sv =====
// Four-word result queue taking up to two tokens per cycle and giving one.
module stl_out_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  stl_pkg::push_t push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output stl_pkg::tok_t  out_tok
);
    import stl_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) mem_reg[wr_ptr_reg] <= push.t0;
        if (push.cnt == 2'd2) mem_reg[wr_ptr_p1]  <= push.t1;
    end

endmodule

// ===== rtl/script_token_lexer.sv =====
// Tokens of an accepted byte are registered in the four-word queue before being offered
// on m_axis; a second token from the same byte follows the first, in order.
// Throughput: one source byte per cycle. A byte gives at most two tokens and never more
// than one per byte on average, so with m_axis_tready held high s_axis_tready stays high;
// it drops only when output stalls leave more than two words in the four-word queue.
// Reset: synchronous active-low aresetn clears lexer state (line count to one) and queue.
module script_token_lexer #(
    parameter int POSITION_BITS = 24,
    parameter int LENGTH_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] token_code, [31:8] start_pos, [47:32] token_len, [48] space_before,
    // [49] newline_before, [73:50] line_no, [74] unterminated, [79:75] zero
    output logic [79:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
    output logic        m_axis_tlast    // last token caused by this byte
);
    import stl_pkg::*;

    push_t push;
    tok_t  out_tok;
    logic  room;
    logic  accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    stl_lexer_core #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .accept (accept),
        .ch     (s_axis_tdata),
        .push   (push)
    );

    stl_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_tok  (out_tok)
    );

    // Pack the token word onto the stream
    assign m_axis_tdata = {5'b0, out_tok.unterminated, out_tok.line_no,
                           out_tok.newline_before, out_tok.space_before,
                           out_tok.len, out_tok.start_pos, out_tok.code};
    assign m_axis_tuser = out_tok.kind;
    assign m_axis_tlast = out_tok.last;

endmodule
